### hw/rtl/assert_macros.svh
// assertion macros included by the capture engine rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STRC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STRC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STRC_ASSERT(label, clk, rst, prop, msg)
`define STRC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### hw/rtl/strc_pkg.sv
// types and constants of the scope trigger ring capture block
`timescale 1ns / 1ps
package strc_pkg;

   localparam int CMD_W    = 2;
   localparam int SAMPLE_W = 12;
   localparam int OFFSET_W = 7;
   localparam int FIELD_IDX_W = 11;
   localparam int ERR_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam int HALF_WINDOW = 64;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_LEVEL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RISING_SLOPE  = 1'b1;

   localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 12'd2048;
   localparam logic [ERR_W-1:0]    ERR_MAX     = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE,
      ST_READ
   } state_type;

endpackage

### hw/rtl/scope_trigger_ring_capture.sv
// scope capture engine: sample ring, level trigger search and window read
// sample writes: the block stays idle after a write and is ready again in the next cycle
// trigger search: walks back from HALF_WINDOW samples before the newest, one ring read per
// step, timing out with the start index after DEPTH/2 steps; window read: registered ring
// read, then registered result beat; synchronous reset clears control state,
// a fill count makes never-written ring entries read as zero, so there is no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scope_trigger_ring_capture #(
   parameter int DEPTH = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [strc_pkg::CMD_W-1:0]         req_command,
   input  logic [strc_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                               req_overflow,
   input  logic [strc_pkg::OFFSET_W-1:0]      req_offset,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [strc_pkg::FIELD_IDX_W-1:0]   rsp_trigger_index,
   output logic                               rsp_timed_out,
   output logic [strc_pkg::FIELD_IDX_W-1:0]   rsp_window_start,
   output logic [strc_pkg::SAMPLE_W-1:0]      rsp_sample_out,
   output logic [strc_pkg::ERR_W-1:0]         rsp_error_count,
   input  logic                               csr_we,
   input  logic [strc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [strc_pkg::SAMPLE_W-1:0]      csr_wdata
);
   import strc_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int HALF_MOD = HALF_WINDOW % DEPTH;
   localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [IDX_W:0]   HALF_X    = (IDX_W + 1)'(HALF_MOD);
   localparam logic [IDX_W:0]   HALF_BACK = (IDX_W + 1)'(DEPTH - HALF_MOD);
   localparam logic [IDX_W-1:0] LIMIT     = IDX_W'(DEPTH / 2);

   function automatic logic [IDX_W-1:0] ring_back_half(input logic [IDX_W-1:0] a);
      logic [IDX_W:0] ax;
      ax = {1'b0, a};
      if (ax >= HALF_X) begin
         ring_back_half = IDX_W'(ax - HALF_X);
      end else begin
         ring_back_half = IDX_W'(ax + HALF_BACK);
      end
   endfunction

   function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
      if (a == '0) begin
         ring_dec = LAST_IDX;
      end else begin
         ring_dec = a - 1'b1;
      end
   endfunction

   function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] a);
      if (a == LAST_IDX) begin
         ring_inc = '0;
      end else begin
         ring_inc = a + 1'b1;
      end
   endfunction

   function automatic logic [IDX_W-1:0] ring_offset(input logic [IDX_W-1:0] a,
                                                    input logic [OFFSET_W-1:0] off);
      logic [IDX_W:0] s;
      s = {1'b0, a} + (IDX_W + 1)'(off);
      if (s >= DEPTH_X) begin
         ring_offset = IDX_W'(s - DEPTH_X);
      end else begin
         ring_offset = IDX_W'(s);
      end
   endfunction

   state_type               state_ff, state_in;
   logic [SAMPLE_W-1:0]     level_ff;
   logic                    rising_ff;
   logic [IDX_W-1:0]        newest_ff, newest_in;
   logic [IDX_W:0]          fill_ff, fill_in;
   logic [ERR_W-1:0]        err_ff, err_in;
   logic [IDX_W-1:0]        wstart_ff, wstart_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        start_ff, start_in;
   logic [IDX_W-1:0]        steps_ff, steps_in;
   logic                    timeout_ff, timeout_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_IDX_W-1:0]  rsp_trig_ff, rsp_trig_in;
   logic                    rsp_to_ff, rsp_to_in;
   logic [FIELD_IDX_W-1:0]  rsp_ws_ff, rsp_ws_in;
   logic [SAMPLE_W-1:0]     rsp_smp_ff, rsp_smp_in;
   logic [ERR_W-1:0]        rsp_err_ff, rsp_err_in;

   logic [SAMPLE_W-1:0]     ring_mem [DEPTH];
   logic [SAMPLE_W-1:0]     rd_data_ff;
   logic                    rd_ok_ff;
   logic                    mem_we;
   logic [IDX_W-1:0]        wr_addr;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;

   logic [SAMPLE_W-1:0]     cur_sample;
   logic                    keep_walking;
   logic                    out_free;
   logic [IDX_W-1:0]        search_start;
   logic [IDX_W-1:0]        idx_back;
   logic [IDX_W-1:0]        found_ws;

   assign cur_sample   = rd_ok_ff ? rd_data_ff : '0;
   assign keep_walking = rising_ff ? (cur_sample < level_ff) : (cur_sample > level_ff);
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign search_start = ring_back_half(newest_ff);
   assign idx_back     = ring_dec(idx_ff);
   assign found_ws     = ring_back_half(idx_ff);
   assign wr_addr      = ring_inc(newest_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= LEVEL_RESET;
         rising_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRIGGER_LEVEL: level_ff  <= csr_wdata;
            CSR_RISING_SLOPE:  rising_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ring store, one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wr_addr] <= req_sample;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
         rd_ok_ff   <= ({1'b0, rd_addr} < fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         newest_ff    <= LAST_IDX;
         fill_ff      <= '0;
         err_ff       <= '0;
         wstart_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         newest_ff    <= newest_in;
         fill_ff      <= fill_in;
         err_ff       <= err_in;
         wstart_ff    <= wstart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      start_ff    <= start_in;
      steps_ff    <= steps_in;
      timeout_ff  <= timeout_in;
      rsp_trig_ff <= rsp_trig_in;
      rsp_to_ff   <= rsp_to_in;
      rsp_ws_ff   <= rsp_ws_in;
      rsp_smp_ff  <= rsp_smp_in;
      rsp_err_ff  <= rsp_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      newest_in    = newest_ff;
      fill_in      = fill_ff;
      err_in       = err_ff;
      wstart_in    = wstart_ff;
      idx_in       = idx_ff;
      start_in     = start_ff;
      steps_in     = steps_ff;
      timeout_in   = timeout_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_trig_in  = rsp_trig_ff;
      rsp_to_in    = rsp_to_ff;
      rsp_ws_in    = rsp_ws_ff;
      rsp_smp_in   = rsp_smp_ff;
      rsp_err_in   = rsp_err_ff;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  CMD_WRITE: begin
                     mem_we    = 1'b1;
                     newest_in = wr_addr;
                     if (fill_ff != DEPTH_X) begin
                        fill_in = fill_ff + 1'b1;
                     end
                     if (req_overflow && (err_ff != ERR_MAX)) begin
                        err_in = err_ff + 1'b1;
                     end
                  end
                  CMD_SEARCH: begin
                     rd_en      = 1'b1;
                     rd_addr    = search_start;
                     idx_in     = search_start;
                     start_in   = search_start;
                     steps_in   = '0;
                     timeout_in = 1'b0;
                     state_in   = ST_SEARCH;
                  end
                  CMD_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = ring_offset(wstart_ff, req_offset);
                     state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            if (!keep_walking) begin
               state_in = ST_DONE;
            end else if (steps_ff == LIMIT) begin
               idx_in     = start_ff;
               timeout_in = 1'b1;
               state_in   = ST_DONE;
            end else begin
               // fetch the next older sample while this one is judged
               rd_en    = 1'b1;
               rd_addr  = idx_back;
               idx_in   = idx_back;
               steps_in = steps_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               wstart_in    = found_ws;
               rsp_valid_in = 1'b1;
               rsp_trig_in  = FIELD_IDX_W'(idx_ff);
               rsp_to_in    = timeout_ff;
               rsp_ws_in    = FIELD_IDX_W'(found_ws);
               rsp_smp_in   = '0;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_trig_in  = '0;
               rsp_to_in    = 1'b0;
               rsp_ws_in    = FIELD_IDX_W'(wstart_ff);
               rsp_smp_in   = cur_sample;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_index = rsp_trig_ff;
   assign rsp_timed_out     = rsp_to_ff;
   assign rsp_window_start  = rsp_ws_ff;
   assign rsp_sample_out    = rsp_smp_ff;
   assign rsp_error_count   = rsp_err_ff;

   `STRC_ASSERT(a_fill_bound, clock, reset, fill_ff <= DEPTH_X, "fill count beyond ring depth")
   `STRC_ASSERT(a_steps_bound, clock, reset,
      (state_ff == ST_SEARCH) |-> (steps_ff <= LIMIT), "search walked past its limit")
   `STRC_ASSERT(a_err_monotonic, clock, reset,
      ##1 (err_ff >= $past(err_ff)), "error count went down")
   `STRC_ASSERT(a_timeout_no_sample, clock, reset,
      (rsp_valid_ff && rsp_to_ff) |-> (rsp_smp_ff == '0), "search beat carries a sample")
   `STRC_ASSERT(a_search_enters, clock, reset,
      (req_valid && req_ready && (req_command == CMD_SEARCH)) |=> (state_ff == ST_SEARCH),
      "search not started")

endmodule

### tb/scope_trigger_ring_capture_tb.sv
// self-checking testbench of the scope trigger ring capture block
`timescale 1ns / 1ps
module scope_trigger_ring_capture_tb;
   import strc_pkg::*;

   localparam int DEPTH              = 2048;
   localparam int SAMPLE_MAX         = (1 << SAMPLE_W) - 1;
   localparam int OFFSET_MAX         = (1 << OFFSET_W) - 1;
   localparam int SEARCH_MAX_CYCLES  = DEPTH / 2 + 4;
   localparam int QUIET_CYCLES       = 8;
   localparam int WATCHDOG_LIMIT     = 20000;
   localparam int OVERFLOW_BURST     = 40;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [CMD_W-1:0] LIVE_CMDS [3] = '{CMD_WRITE, CMD_SEARCH, CMD_READ};

   typedef struct packed {
      logic [FIELD_IDX_W-1:0] trigger_index;
      logic                   timed_out;
      logic [FIELD_IDX_W-1:0] window_start;
      logic [SAMPLE_W-1:0]    sample_out;
      logic [ERR_W-1:0]       error_count;
   } capture_result_type;

   class ring_capture_tracker_type;
      logic [SAMPLE_W-1:0]    ring [DEPTH];
      logic [FIELD_IDX_W-1:0] newest;
      logic [FIELD_IDX_W-1:0] window_base;
      logic [ERR_W-1:0]       overflow_events;
      logic [SAMPLE_W-1:0]    level;
      logic                   rising;
      capture_result_type     pending_results[$];
      int errors, writes, searches, timeouts, reads, checked;

      function void clear();
         foreach (ring[i]) ring[i] = '0;
         newest          = FIELD_IDX_W'(DEPTH - 1);
         window_base     = '0;
         overflow_events = '0;
         level           = LEVEL_RESET;
         rising          = 1'b1;
         pending_results.delete();
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] index, logic [SAMPLE_W-1:0] data);
         case (index)
            CSR_TRIGGER_LEVEL: level = data;
            CSR_RISING_SLOPE:  rising = data[0];
            default: ;
         endcase
      endfunction

      function void accept_command(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] value,
                                   logic ovf, logic [OFFSET_W-1:0] offset);
         capture_result_type r;
         logic [FIELD_IDX_W-1:0] start, idx, pos;
         int steps;
         r = '0;
         case (cmd)
            CMD_WRITE: begin
               if (ovf && overflow_events != ERR_MAX) overflow_events++;
               newest++;
               ring[newest] = value;
               writes++;
            end
            CMD_SEARCH: begin
               start = FIELD_IDX_W'(newest - HALF_WINDOW);
               idx = start;
               steps = 0;
               while (rising ? (ring[idx] < level) : (ring[idx] > level)) begin
                  idx--;
                  steps++;
                  if (steps > DEPTH / 2) begin
                     idx = start;
                     r.timed_out = 1'b1;
                     break;
                  end
               end
               window_base     = FIELD_IDX_W'(idx - HALF_WINDOW);
               r.trigger_index = idx;
               r.window_start  = window_base;
               r.error_count   = overflow_events;
               pending_results.push_back(r);
               searches++;
               if (r.timed_out) timeouts++;
            end
            CMD_READ: begin
               pos            = FIELD_IDX_W'(window_base + offset);
               r.window_start = window_base;
               r.sample_out   = ring[pos];
               r.error_count  = overflow_events;
               pending_results.push_back(r);
               reads++;
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void match_result(capture_result_type got);
         capture_result_type want;
         if (pending_results.size() == 0) begin
            $error("result beat with no search or read waiting for it");
            errors++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         compare_field("trigger_index", want.trigger_index, got.trigger_index);
         compare_field("timed_out", want.timed_out, got.timed_out);
         compare_field("window_start", want.window_start, got.window_start);
         compare_field("sample_out", want.sample_out, got.sample_out);
         compare_field("error_count", want.error_count, got.error_count);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CMD_W-1:0]       req_command;
   logic [SAMPLE_W-1:0]    req_sample;
   logic                   req_overflow;
   logic [OFFSET_W-1:0]    req_offset;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [FIELD_IDX_W-1:0] rsp_trigger_index;
   logic                   rsp_timed_out;
   logic [FIELD_IDX_W-1:0] rsp_window_start;
   logic [SAMPLE_W-1:0]    rsp_sample_out;
   logic [ERR_W-1:0]       rsp_error_count;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [SAMPLE_W-1:0]    csr_wdata;

   ring_capture_tracker_type tracker;
   int send_idle_pct;
   int rsp_stall_pct;

   scope_trigger_ring_capture #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_sample(req_sample),
      .req_overflow(req_overflow),
      .req_offset(req_offset),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_trigger_index(rsp_trigger_index),
      .rsp_timed_out(rsp_timed_out),
      .rsp_window_start(rsp_window_start),
      .rsp_sample_out(rsp_sample_out),
      .rsp_error_count(rsp_error_count),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin : rsp_side
      capture_result_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_trigger_index, rsp_timed_out, rsp_window_start, rsp_sample_out,
                 rsp_error_count};
         tracker.match_result(seen);
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] value,
                               input logic ovf, input logic [OFFSET_W-1:0] offset);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_sample   <= value;
      req_overflow <= ovf;
      req_offset   <= offset;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.accept_command(cmd, value, ovf, offset);
   endtask

   task automatic set_registers(input logic [SAMPLE_W-1:0] level, input logic rising);
      csr_we    <= 1'b1;
      csr_index <= CSR_TRIGGER_LEVEL;
      csr_wdata <= level;
      @(posedge clock);
      tracker.set_reg(CSR_TRIGGER_LEVEL, level);
      csr_index <= CSR_RISING_SLOPE;
      csr_wdata <= SAMPLE_W'(rising);
      @(posedge clock);
      tracker.set_reg(CSR_RISING_SLOPE, SAMPLE_W'(rising));
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic set_pacing(input int idle, input int stall);
      send_idle_pct = idle;
      rsp_stall_pct = stall;
   endtask

   // biased samples sit mostly on the side that keeps the search walking
   function automatic logic [SAMPLE_W-1:0] pick_sample(input bit biased);
      int lvl;
      lvl = int'(tracker.level);
      if (biased && $urandom_range(9) != 0) begin
         if (tracker.rising && lvl > 0) return SAMPLE_W'($urandom_range(lvl - 1, 0));
         if (!tracker.rising && lvl < SAMPLE_MAX)
            return SAMPLE_W'($urandom_range(SAMPLE_MAX, lvl + 1));
      end
      return SAMPLE_W'($urandom_range(SAMPLE_MAX));
   endfunction

   task automatic random_capture(inout int sent);
      int burst, nreads;
      bit biased;
      burst  = ($urandom_range(7) == 0) ? $urandom_range(160, 64) : $urandom_range(24, 1);
      biased = 1'($urandom_range(1));
      nreads = $urandom_range(4, 1);
      repeat (burst)
         send_command(CMD_WRITE, pick_sample(biased), ($urandom_range(7) == 0),
                      OFFSET_W'($urandom_range(OFFSET_MAX)));
      send_command(CMD_SEARCH, SAMPLE_W'($urandom_range(SAMPLE_MAX)), 1'($urandom_range(1)),
                   OFFSET_W'($urandom_range(OFFSET_MAX)));
      repeat (nreads)
         send_command(CMD_READ, SAMPLE_W'($urandom_range(SAMPLE_MAX)), 1'($urandom_range(1)),
                      OFFSET_W'($urandom_range(OFFSET_MAX)));
      sent += burst + 1 + nreads;
   endtask

   task automatic run_random(input int count);
      int sent, pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_command(CMD_UNUSED, SAMPLE_W'($urandom_range(SAMPLE_MAX)),
                         1'($urandom_range(1)), OFFSET_W'($urandom_range(OFFSET_MAX)));
         end else if (pick < 75) begin
            random_capture(sent);
         end else begin
            send_command(LIVE_CMDS[2'($urandom_range(2))], pick_sample(1'($urandom_range(1))),
                         1'($urandom_range(1)), OFFSET_W'($urandom_range(OFFSET_MAX)));
            sent++;
         end
      end
   endtask

   task automatic run_directed();
      // ring all zeros after reset, so the rising search runs out of steps
      send_command(CMD_SEARCH, '0, 1'b0, '0);
      send_command(CMD_READ, '0, 1'b0, '0);
      send_command(CMD_READ, '0, 1'b0, OFFSET_W'(OFFSET_MAX));
      send_command(CMD_UNUSED, SAMPLE_W'(SAMPLE_MAX), 1'b1, OFFSET_W'(OFFSET_MAX));
      send_command(CMD_WRITE, '0, 1'b0, '0);
      send_command(CMD_WRITE, SAMPLE_W'(SAMPLE_MAX), 1'b1, OFFSET_W'(OFFSET_MAX));
      send_command(CMD_WRITE, LEVEL_RESET, 1'b1, '0);
      send_command(CMD_WRITE, LEVEL_RESET - 1'b1, 1'b0, '0);
      send_command(CMD_WRITE, LEVEL_RESET + 1'b1, 1'b1, '0);
      // window reads at the top of the offset range
      for (int off = OFFSET_MAX - 4; off <= OFFSET_MAX; off++)
         send_command(CMD_READ, '0, 1'b0, OFFSET_W'(off));
      send_command(CMD_SEARCH, SAMPLE_W'(SAMPLE_MAX), 1'b1, OFFSET_W'(OFFSET_MAX));
      send_command(CMD_READ, SAMPLE_W'(SAMPLE_MAX), 1'b1, OFFSET_W'(HALF_WINDOW));
   endtask

   task automatic overflow_burst();
      repeat (OVERFLOW_BURST)
         send_command(CMD_WRITE, SAMPLE_W'($urandom_range(SAMPLE_MAX - 1)), 1'b1,
                      OFFSET_W'($urandom_range(OFFSET_MAX)));
      send_command(CMD_SEARCH, '0, 1'b0, '0);
      send_command(CMD_READ, '0, 1'b0, '0);
      send_command(CMD_READ, '0, 1'b0, OFFSET_W'(OFFSET_MAX));
      send_command(CMD_WRITE, SAMPLE_W'(SAMPLE_MAX), 1'b1, '0);
      send_command(CMD_SEARCH, '0, 1'b0, '0);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_command  = CMD_WRITE;
      req_sample   = '0;
      req_overflow = 1'b0;
      req_offset   = '0;
      rsp_ready    = 1'b0;
      csr_we       = 1'b0;
      csr_index    = CSR_TRIGGER_LEVEL;
      csr_wdata    = '0;
      tracker      = new();
      tracker.clear();
      set_pacing(0, 0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(110);

      settle();
      set_registers('0, 1'b0);
      set_pacing(87, 0);
      run_random(90);

      settle();
      set_registers(SAMPLE_W'(SAMPLE_MAX), 1'b1);
      set_pacing(0, 87);
      run_random(90);

      settle();
      set_registers(SAMPLE_W'($urandom_range(SAMPLE_MAX)), 1'($urandom_range(1)));
      set_pacing(25, 25);
      run_random(110);

      settle();
      set_registers(SAMPLE_W'($urandom_range(SAMPLE_MAX)), 1'($urandom_range(1)));
      set_pacing(0, 0);
      run_random(60);

      // a burst of overflow writes followed by searches and reads
      settle();
      set_registers(SAMPLE_W'(SAMPLE_MAX), 1'b1);
      overflow_burst();

      settle();
      repeat (SEARCH_MAX_CYCLES) @(posedge clock);
      $display("run covered %0d sample writes, %0d trigger searches (%0d timed out)",
               tracker.writes, tracker.searches, tracker.timeouts);
      $display("and %0d window reads; %0d result beats checked, error count ended at %0d",
               tracker.reads, tracker.checked, tracker.overflow_events);
      if (tracker.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/strc_pkg.sv
hw/rtl/scope_trigger_ring_capture.sv
tb/scope_trigger_ring_capture_tb.sv
